>>> rtl/qdps_pkg.sv
// Shared types, constants and register codes for the quadrature decoder
// with period-based speed measurement. No dependencies.
package qdps_pkg;

  localparam int OVF_W      = 9;
  localparam int PERIOD_W   = 16;
  localparam int FREQ_W     = 27;
  localparam int STAMP_W    = 16;
  localparam int POS_W      = 32;
  localparam int INTV_W     = 26;
  localparam int SPEED_W    = 28;
  localparam int PROD_W     = OVF_W + PERIOD_W;
  localparam int DIFF_W     = 27;
  localparam int DIV_STEPS  = FREQ_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FREQ_W;
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 88;
  localparam int M_TUSER_W  = 1;

  localparam int DEF_TIMEOUT_TICKS = 500;
  localparam int DEF_TIMER_BITS    = 16;

  localparam logic [1:0] REQ_EDGE_A = 2'd0;
  localparam logic [1:0] REQ_EDGE_B = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] MODE_1X = 2'd0;
  localparam logic [1:0] MODE_2X = 2'd1;
  localparam logic [1:0] MODE_4X = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQUENCY = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'hFFFF;
  localparam logic [FREQ_W-1:0]   FREQ_RST   = 27'd1000000;

  typedef struct packed {
    logic                enable;
    logic [1:0]          mode;
    logic                reverse;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req;
    logic               level_a;
    logic               level_b;
    logic [STAMP_W-1:0] stamp;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

>>> rtl/quadrature_decoder_with_period_speed.sv
// Quadrature decoder with period-based speed; top level, config registers
// and stream handshake. Depends on qdps_pkg, qdps_mul, qdps_track, qdps_div.
// An input transaction passes the multiply steps, the tracking update, the divider load,
// the divide steps and the load into the output register. A new input is taken only in
// idle, after the last one is through, and while the previous result waits in the output
// register; a full output register holds the finished result back. Reset is synchronous.
module quadrature_decoder_with_period_speed #(
  parameter int TIMEOUT_TICKS = qdps_pkg::DEF_TIMEOUT_TICKS,
  parameter int TIMER_BITS    = qdps_pkg::DEF_TIMER_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qdps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qdps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // level_a, level_b, timer_value[15:0], zero fill
  input  logic [qdps_pkg::S_TDATA_W-1:0]    s_tdata,
  // req_type[1:0]
  input  logic [qdps_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // position[31:0], interval[25:0], speed_cps[27:0], zero fill
  output logic [qdps_pkg::M_TDATA_W-1:0]    m_tdata,
  // counted
  output logic [qdps_pkg::M_TUSER_W-1:0]    m_tuser
);
  import qdps_pkg::*;

  cfg_t   cfg;
  item_t  item;
  state_t state;
  state_t state_next;

  logic accept;
  logic upd;
  logic div_start;
  logic out_load;
  logic out_free;

  logic                       mul_done;
  logic [PROD_W-1:0]          prod;
  logic [OVF_W-1:0]           ovf;
  logic [POS_W-1:0]           position;
  logic signed [INTV_W-1:0]   interval;
  logic                       counted;
  logic                       div_done;
  logic signed [SPEED_W-1:0]  speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable  <= 1'b0;
      cfg.mode    <= MODE_1X;
      cfg.reverse <= 1'b0;
      cfg.period  <= PERIOD_RST;
      cfg.freq    <= FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:          cfg.enable  <= cfg_data[0];
        REG_RESOLUTION_MODE: cfg.mode    <= cfg_data[1:0];
        REG_REVERSE:         cfg.reverse <= cfg_data[0];
        REG_TIMER_PERIOD:    cfg.period  <= cfg_data[PERIOD_W-1:0];
        REG_TIMER_FREQUENCY: cfg.freq    <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item.req     <= s_tuser[1:0];
      item.level_a <= s_tdata[0];
      item.level_b <= s_tdata[1];
      item.stamp   <= s_tdata[STAMP_W+1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    upd        = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          upd        = 1'b1;
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  qdps_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (ovf),
    .b     (cfg.period),
    .done  (mul_done),
    .prod  (prod)
  );

  qdps_track #(
    .TIMEOUT_TICKS (TIMEOUT_TICKS),
    .TIMER_BITS    (TIMER_BITS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .item     (item),
    .cfg      (cfg),
    .prod     (prod),
    .ovf      (ovf),
    .position (position),
    .interval (interval),
    .counted  (counted)
  );

  qdps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg.freq),
    .interval (interval),
    .reverse  (cfg.reverse),
    .done     (div_done),
    .speed    (speed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, speed, interval, position};
      m_tuser <= counted;
    end
  end

endmodule

>>> rtl/qdps_mul.sv
// Bit-serial shift-and-add multiplier: overflow count times timer period.
// Depends on qdps_pkg.
module qdps_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [qdps_pkg::OVF_W-1:0]    a,
  input  logic [qdps_pkg::PERIOD_W-1:0] b,
  output logic                         done,
  output logic [qdps_pkg::PROD_W-1:0]   prod
);
  import qdps_pkg::*;

  localparam int CNT_W = $clog2(OVF_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(OVF_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [OVF_W-1:0]  mplier;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mplier <= a;
      mcand  <= PROD_W'(b);
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
    end
  end

endmodule

>>> rtl/qdps_div.sv
// Radix-2 restoring divider: timer frequency over the signed interval,
// truncated toward zero, one quotient bit per cycle. Depends on qdps_pkg.
module qdps_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [qdps_pkg::FREQ_W-1:0]         dividend,
  input  logic signed [qdps_pkg::INTV_W-1:0]  interval,
  input  logic                                reverse,
  output logic                                done,
  output logic signed [qdps_pkg::SPEED_W-1:0] speed
);
  import qdps_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_STEPS - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [INTV_W-1:0] dmag;
  logic              neg;
  logic [INTV_W-1:0] rem;
  logic [FREQ_W-1:0] quo;

  logic signed [INTV_W:0] dv;
  logic [INTV_W:0]        mag;
  logic [INTV_W:0]        sh;
  logic [INTV_W+1:0]      diff;
  logic [SPEED_W-1:0]     qx;

  always_comb begin
    dv = {interval[INTV_W-1], interval};
    if (reverse) begin
      dv = -dv;
    end
    mag  = dv[INTV_W] ? -dv : dv;
    sh   = {rem, quo[FREQ_W-1]};
    diff = {1'b0, sh} - {2'b00, dmag};
    qx   = SPEED_W'(quo);
    if (dmag == '0) begin
      speed = '0;
    end else if (neg) begin
      speed = -qx;
    end else begin
      speed = qx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= mag[INTV_W-1:0];
      neg  <= dv[INTV_W];
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      if (!diff[INTV_W+1]) begin
        rem <= diff[INTV_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b1};
      end else begin
        rem <= sh[INTV_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/qdps_track.sv
// Edge decoding and tracking state: position, overflow count, time mark,
// interval and restart flag. Depends on qdps_pkg.
module qdps_track #(
  parameter int TIMEOUT_TICKS = qdps_pkg::DEF_TIMEOUT_TICKS,
  parameter int TIMER_BITS    = qdps_pkg::DEF_TIMER_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               upd,
  input  qdps_pkg::item_t                    item,
  input  qdps_pkg::cfg_t                     cfg,
  input  logic [qdps_pkg::PROD_W-1:0]        prod,
  output logic [qdps_pkg::OVF_W-1:0]         ovf,
  output logic [qdps_pkg::POS_W-1:0]         position,
  output logic signed [qdps_pkg::INTV_W-1:0] interval,
  output logic                               counted
);
  import qdps_pkg::*;

  localparam logic [OVF_W-1:0] TIMEOUT = OVF_W'(TIMEOUT_TICKS);
  localparam logic [POS_W-1:0] ONE     = POS_W'(1);

  logic [TIMER_BITS-1:0] mark;
  logic                  first;

  logic [POS_W-1:0]      position_next;
  logic [OVF_W-1:0]      ovf_next;
  logic [TIMER_BITS-1:0] mark_next;
  logic [INTV_W-1:0]     interval_next;
  logic                  first_next;
  logic                  counted_next;

  logic [TIMER_BITS-1:0] stamp_m;
  logic                  two_or_four;
  logic                  do_count;
  logic                  up;
  logic                  restart;
  logic                  tick;
  logic [DIFF_W-1:0]     elapsed;
  logic [DIFF_W-1:0]     elapsed_dir;
  logic [OVF_W-1:0]      ovf_inc;

  always_comb begin
    stamp_m     = item.stamp[TIMER_BITS-1:0];
    two_or_four = cfg.mode inside {MODE_2X, MODE_4X};
    do_count    = 1'b0;
    up          = 1'b0;
    restart     = 1'b0;
    tick        = 1'b0;
    case (item.req)
      REQ_EDGE_A: begin
        restart = 1'b1;
        if (item.level_a) begin
          do_count = 1'b1;
          up       = !item.level_b;
        end else if (two_or_four) begin
          do_count = 1'b1;
          up       = item.level_b;
        end
      end
      REQ_EDGE_B: begin
        if (cfg.mode == MODE_4X) begin
          restart  = 1'b1;
          do_count = 1'b1;
          up       = item.level_a ~^ item.level_b;
        end
      end
      REQ_TICK: begin
        tick = 1'b1;
      end
      default: ;
    endcase

    elapsed     = DIFF_W'(prod) + DIFF_W'(stamp_m) - DIFF_W'(mark);
    elapsed_dir = up ? elapsed : -elapsed;
    ovf_inc     = ovf + 1'b1;

    position_next = position;
    ovf_next      = ovf;
    mark_next     = mark;
    interval_next = interval;
    first_next    = first;
    counted_next  = counted;

    if (upd) begin
      counted_next = cfg.enable & do_count;
      if (cfg.enable) begin
        if (do_count) begin
          position_next = position + (((up ^ cfg.reverse)) ? ONE : '1);
          first_next    = 1'b0;
          if (!first) begin
            interval_next = elapsed_dir[INTV_W-1:0];
          end
        end
        if (restart) begin
          ovf_next  = '0;
          mark_next = stamp_m;
        end
        if (tick) begin
          ovf_next = ovf_inc;
          if (ovf_inc == TIMEOUT) begin
            ovf_next      = '0;
            interval_next = '0;
            first_next    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      ovf      <= '0;
      mark     <= '0;
      interval <= '0;
      first    <= 1'b1;
      counted  <= 1'b0;
    end else begin
      position <= position_next;
      ovf      <= ovf_next;
      mark     <= mark_next;
      interval <= interval_next;
      first    <= first_next;
      counted  <= counted_next;
    end
  end

endmodule

>>> test/tb_quadrature_decoder_with_period_speed.sv
`timescale 1ns / 100ps
// Self-checking bench for quadrature_decoder_with_period_speed: directed table, then
// random encoder motion and noise under several idle/stall patterns and register settings.
// Depends on qdps_pkg and the RTL top level only.
module tb_quadrature_decoder_with_period_speed;
  import qdps_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         STOP_TICKS  = DEF_TIMEOUT_TICKS;
  localparam int         LONG_TICKS  = 260;
  localparam int         PHASE_ITEMS = 24;
  localparam int         DRAIN_WAIT  = 48;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [INTV_W-1:0]  intv;
    logic [SPEED_W-1:0] spd;
    logic               cnt;
  } result_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [1:0]            req;
    logic                  la;
    logic                  lb;
    logic [STAMP_W-1:0]    stamp;
    logic                  chk;
    result_t               want;
  } stim_row_t;

  localparam result_t NONE = '0;

  localparam stim_row_t DIRECTED [28] = '{
    // disabled after reset, then an unused request
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'd100, 1'b1, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_UNUSED, 1'b1, 1'b1, 16'hFFFF, 1'b1, NONE},
    '{1'b1, REG_ENABLE, 27'd1, REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    // 1X: first count only restarts the measurement
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'd0, 1'b1,
      '{32'd1, 26'd0, 28'd0, 1'b1}},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'd1000, 1'b1,
      '{32'd2, 26'd1000, 28'd1000, 1'b1}},
    // falling A at 1X: no count, mark restarted
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b0, 1'b1, 16'd1500, 1'b1,
      '{32'd2, 26'd1000, 28'd1000, 1'b0}},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b1, 16'd2000, 1'b1,
      '{32'd1, -26'sd500, -28'sd2000, 1'b1}},
    // B ignored below 4X
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b1, 1'b1, 16'd3000, 1'b1,
      '{32'd1, -26'sd500, -28'sd2000, 1'b0}},
    '{1'b0, REG_ENABLE, 27'd0, REQ_TICK, 1'b0, 1'b0, 16'd0, 1'b1,
      '{32'd1, -26'sd500, -28'sd2000, 1'b0}},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'hFFFF, 1'b0, NONE},
    '{1'b1, REG_RESOLUTION_MODE, 27'(MODE_2X), REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b0, 1'b1, 16'd10, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b0, 1'b0, 16'd20, 1'b0, NONE},
    '{1'b1, REG_RESOLUTION_MODE, 27'(MODE_4X), REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b1, 1'b1, 16'd40, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b0, 1'b1, 16'd70, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b0, 1'b0, 16'd110, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b1, 1'b0, 16'd160, 1'b0, NONE},
    '{1'b1, REG_REVERSE, 27'd1, REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'h8000, 1'b0, NONE},
    '{1'b1, REG_TIMER_PERIOD, 27'd0, REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    '{1'b1, REG_TIMER_FREQUENCY, 27'h7FFFFFF, REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0, NONE},
    // zero period: tick adds nothing, interval of one tick gives full-scale speed
    '{1'b0, REG_ENABLE, 27'd0, REQ_TICK, 1'b1, 1'b1, 16'h1234, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b1, 1'b0, 16'h8001, 1'b0, NONE},
    '{1'b1, REG_RESOLUTION_MODE, 27'(MODE_UNUSED), REQ_EDGE_A, 1'b0, 1'b0, 16'd0, 1'b0,
      NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_A, 1'b0, 1'b1, 16'd5, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_EDGE_B, 1'b1, 1'b1, 16'd6, 1'b0, NONE},
    '{1'b0, REG_ENABLE, 27'd0, REQ_UNUSED, 1'b0, 1'b0, 16'd7, 1'b0, NONE}
  };

  localparam logic [1:0] PH_MODE [8] = '{MODE_4X, MODE_2X, MODE_1X, MODE_4X,
                                          MODE_UNUSED, MODE_4X, MODE_2X, MODE_4X};
  localparam int PH_PERIOD [8] = '{65535, 1, 0, 0, 65535, 0, 1000, 65535};
  localparam int PH_FREQ   [8] = '{1000000, 1, 100000000, 134217727, 0, 0, 0, 1000000};
  localparam int PH_IDLE   [4] = '{0, 85, 0, 35};
  localparam int PH_STALL  [4] = '{0, 0, 85, 35};

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  quadrature_decoder_with_period_speed dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // decoder model: registers and state
  logic                r_en     = 1'b0;
  logic [1:0]          r_mode   = MODE_1X;
  logic                r_rev    = 1'b0;
  logic [PERIOD_W-1:0] r_period = PERIOD_RST;
  logic [FREQ_W-1:0]   r_freq   = FREQ_RST;
  logic [POS_W-1:0]    m_pos    = '0;
  logic [OVF_W-1:0]    m_ovf    = '0;
  logic [STAMP_W-1:0]  m_mark   = '0;
  int                  m_intv   = 0;
  logic                m_fresh  = 1'b1;

  result_t pending_results [$];
  result_t got;
  result_t want_now;
  int      idle_pct    = 0;
  int      stall_pct   = 0;
  int      fail_count  = 0;
  int      n_checked   = 0;
  int      n_moves     = 0;
  int      n_timeouts  = 0;
  int      n_writes    = 0;
  int      cycle_count = 0;
  logic    enc_a = 1'b0;
  logic    enc_b = 1'b0;
  logic    enc_fwd = 1'b1;
  int      tbase = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void count_step(input logic up, input logic [STAMP_W-1:0] stamp);
    longint elapsed;
    elapsed = longint'(m_ovf) * longint'(r_period) + longint'(stamp) - longint'(m_mark);
    if (up) begin
      m_pos = m_pos + (r_rev ? 32'hFFFF_FFFF : 32'd1);
    end else begin
      m_pos = m_pos - (r_rev ? 32'hFFFF_FFFF : 32'd1);
      elapsed = -elapsed;
    end
    if (m_fresh) m_fresh = 1'b0;
    else m_intv = int'(elapsed);
  endfunction

  function automatic result_t decode_event(input logic [1:0] req, input logic la,
                                           input logic lb, input logic [STAMP_W-1:0] stamp);
    result_t          r;
    logic [POS_W-1:0] prev;
    longint           divisor;
    longint           speed;
    prev = m_pos;
    speed = 0;
    if (r_en) begin
      case (req)
        REQ_EDGE_A: begin
          if (la) count_step(!lb, stamp);
          else if (r_mode == MODE_2X || r_mode == MODE_4X) count_step(lb, stamp);
          m_ovf = '0;
          m_mark = stamp;
        end
        REQ_EDGE_B: begin
          if (r_mode == MODE_4X) begin
            count_step(lb ? la : !la, stamp);
            m_ovf = '0;
            m_mark = stamp;
          end
        end
        REQ_TICK: begin
          m_ovf = m_ovf + 1'b1;
          if (m_ovf == OVF_W'(STOP_TICKS)) begin
            m_intv = 0;
            m_ovf = '0;
            m_fresh = 1'b1;
            n_timeouts++;
          end
        end
        default: ;
      endcase
    end
    divisor = r_rev ? -longint'(m_intv) : longint'(m_intv);
    if (divisor != 0) speed = longint'(r_freq) / divisor;
    r.pos = m_pos;
    r.intv = m_intv[INTV_W-1:0];
    r.spd = speed[SPEED_W-1:0];
    r.cnt = (m_pos != prev);
    return r;
  endfunction

  task automatic issue_event(input logic [1:0] req, input logic la, input logic lb,
                             input logic [STAMP_W-1:0] stamp,
                             input logic fixed_on = 1'b0, input result_t fixed = '0);
    result_t want;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {6'd0, stamp, lb, la};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = decode_event(req, la, lb, stamp);
    pending_results.push_back(fixed_on ? fixed : want);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:          r_en = val[0];
      REG_RESOLUTION_MODE: r_mode = val[1:0];
      REG_REVERSE:         r_rev = val[0];
      REG_TIMER_PERIOD:    r_period = val[PERIOD_W-1:0];
      REG_TIMER_FREQUENCY: r_freq = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly legal quadrature motion with time-base overflows, plus raw noise
  task automatic run_phase(input int n_items);
    int span;
    int wraps;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_results();
      if ($urandom_range(99) < 80) begin
        span = (r_period == 0) ? 65536 : int'(r_period);
        tbase += ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 400);
        wraps = tbase / span;
        tbase = tbase % span;
        for (int w = 0; w < wraps && w < 3; w++)
          issue_event(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
        if ($urandom_range(9) == 0) enc_fwd = !enc_fwd;
        if ((enc_a == enc_b) == enc_fwd) begin
          enc_a = !enc_a;
          issue_event(REQ_EDGE_A, enc_a, enc_b, 16'(tbase));
        end else begin
          enc_b = !enc_b;
          issue_event(REQ_EDGE_B, enc_a, enc_b, 16'(tbase));
        end
      end else begin
        issue_event(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    16'($urandom));
      end
    end
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[31:0], m_tdata[57:32], m_tdata[85:58], m_tuser[0]};
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: %h", got);
        fail_count++;
      end else begin
        want_now = pending_results.pop_front();
        n_checked++;
        if (got.cnt) n_moves++;
        if (got.pos !== want_now.pos) begin
          $error("position: expected %0d, got %0d", $signed(want_now.pos), $signed(got.pos));
          fail_count++;
        end
        if (got.intv !== want_now.intv) begin
          $error("interval: expected %0d, got %0d", $signed(want_now.intv), $signed(got.intv));
          fail_count++;
        end
        if (got.spd !== want_now.spd) begin
          $error("speed_cps: expected %0d, got %0d", $signed(want_now.spd), $signed(got.spd));
          fail_count++;
        end
        if (got.cnt !== want_now.cnt) begin
          $error("counted: expected %0b, got %0b", want_now.cnt, got.cnt);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].wr) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        issue_event(DIRECTED[i].req, DIRECTED[i].la, DIRECTED[i].lb, DIRECTED[i].stamp,
                    DIRECTED[i].chk, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      idle_pct  = PH_IDLE[ph % 4];
      stall_pct = PH_STALL[ph % 4];
      write_reg(REG_ENABLE, (ph == 5) ? 27'd0 : 27'd1);
      write_reg(REG_RESOLUTION_MODE, 27'(PH_MODE[ph]));
      write_reg(REG_REVERSE, 27'(ph % 2));
      write_reg(REG_TIMER_PERIOD, (ph == 2 || ph == 5) ? 27'($urandom_range(2, 65534))
                                                       : 27'(PH_PERIOD[ph]));
      write_reg(REG_TIMER_FREQUENCY, (ph >= 4 && ph <= 6) ? 27'($urandom_range(1, 100000000))
                                                          : 27'(PH_FREQ[ph]));
      run_phase(PHASE_ITEMS);
    end

    // long interval with the top overflow bit in use, then a stop timeout and restart
    drain_results();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_ENABLE, 27'd1);
    write_reg(REG_RESOLUTION_MODE, 27'(MODE_4X));
    write_reg(REG_REVERSE, 27'd0);
    write_reg(REG_TIMER_PERIOD, 27'd65535);
    write_reg(REG_TIMER_FREQUENCY, 27'd100000000);
    issue_event(REQ_EDGE_A, 1'b1, 1'b0, 16'd0);
    issue_event(REQ_EDGE_A, 1'b1, 1'b0, 16'd0);
    repeat (LONG_TICKS) issue_event(REQ_TICK, 1'b0, 1'b0, 16'($urandom));
    issue_event(REQ_EDGE_A, 1'b0, 1'b0, 16'hFFFF);
    repeat (STOP_TICKS) issue_event(REQ_TICK, 1'b1, 1'b0, 16'($urandom));
    issue_event(REQ_EDGE_A, 1'b1, 1'b0, 16'd300);
    issue_event(REQ_EDGE_A, 1'b0, 1'b1, 16'd900);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("%0d result transactions checked, %0d counted, %0d stop timeouts, %0d reg writes",
             n_checked, n_moves, n_timeouts, n_writes);
    $display("covered 1X/2X/4X/unused modes, reversal, disable, zero and full-scale timing");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
